@@ design/uirs_pkg.sv @@
// ----------------------------------------------------------------------------
// uirs_pkg: shared types for the user registry and session unit
// Request codes, fixed port widths and the control structs that pass
// between the sequencer and the two table rows.
// ----------------------------------------------------------------------------
`default_nettype none

package uirs_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned USER_ID_W   = 16;
  localparam int unsigned COUNT_OUT_W = 5;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    OP_REGISTER  = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_LOGIN     = 3'd2,
    OP_LOGOUT    = 3'd3,
    OP_QUERY_SES = 3'd4,
    OP_QUERY_REG = 3'd5
  } req_e;

  // Update command to one table row
  typedef struct packed {
    logic append;  // write id at slot [count], count + 1
    logic drop;    // remove lowest match, close the gap, count - 1
  } row_cmd_t;

  // Lookup status from one table row
  typedef struct packed {
    logic hit;     // id present below count
    logic full;    // count at capacity
  } row_stat_t;

endpackage

`default_nettype wire

@@ design/uirs_cell.sv @@
// ----------------------------------------------------------------------------
// uirs_cell: one slot of an ID table
// Holds one ID, compares it against the request ID and takes its upper
// neighbor's value when an entry at or below it is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module uirs_cell #(
  parameter int unsigned ID_W  = 16,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  wire logic               clk_i,
  input  wire uirs_pkg::row_cmd_t cmd_i,
  input  wire logic [ID_W-1:0]    id_i,
  input  wire logic [CNT_W-1:0]   count_i,
  input  wire logic [ID_W-1:0]    upper_i,
  input  wire logic               chain_i,
  output logic                    chain_o,
  output logic [ID_W-1:0]         value_o
);

  logic [ID_W-1:0] value_q;
  logic            live;
  logic            match;

  // Slot is live only below the fill count
  assign live    = CNT_W'(IDX) < count_i;
  assign match   = live && (value_q == id_i);
  // Any match at this slot or below
  assign chain_o = chain_i | match;
  assign value_o = value_q;

  // Append writes the slot at count; a drop shifts everything from the
  // first match upward down by one
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && (count_i == CNT_W'(IDX))) begin
      value_q <= id_i;
    end else if (cmd_i.drop && chain_o) begin
      value_q <= upper_i;
    end
  end

endmodule

`default_nettype wire

@@ design/uirs_row.sv @@
// ----------------------------------------------------------------------------
// uirs_row: one ID table as a row of cells
// Chains DEPTH cells, keeps the fill count and reports hit and full.
// ----------------------------------------------------------------------------
`default_nettype none

module uirs_row #(
  parameter  int unsigned DEPTH = 16,
  parameter  int unsigned ID_W  = 16,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire uirs_pkg::row_cmd_t  cmd_i,
  input  wire logic [ID_W-1:0]     id_i,
  output uirs_pkg::row_stat_t      stat_o,
  output logic [CNT_W-1:0]         count_o,
  output logic [CNT_W-1:0]         count_next_o
);

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic [ID_W-1:0]  value [DEPTH];
  logic [DEPTH:0]   chain;

  assign chain[0] = 1'b0;

  // Row of slots, each passing its value down and its match flag up
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] upper;
    if (i == DEPTH - 1) begin : g_top
      assign upper = value[i];
    end else begin : g_mid
      assign upper = value[i+1];
    end

    uirs_cell #(
      .ID_W  (ID_W),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_i),
      .id_i    (id_i),
      .count_i (count_q),
      .upper_i (upper),
      .chain_i (chain[i]),
      .chain_o (chain[i+1]),
      .value_o (value[i])
    );
  end

  assign stat_o.hit  = chain[DEPTH];
  assign stat_o.full = (count_q == CNT_W'(DEPTH));

  // Fill count update
  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.drop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

`default_nettype wire

@@ design/user_id_registry_and_sessions_unit.sv @@
// ----------------------------------------------------------------------------
// user_id_registry_and_sessions_unit: user registry and session tables
// Keeps a table of registered user IDs and a table of logged-in sessions.
// ----------------------------------------------------------------------------
// The request beat is captured in the idle state; in the execute state every
// slot of both tables compares the ID in parallel, the first-match flag
// ripples along the row of slots and the update (append at the fill count,
// or drop with the slots above shifting down by one) is written together
// with the result. The next request is taken only once the update is
// written, so no new request is accepted while one is executing; a stalled
// result holds the update until its register frees. There is no clearing
// pass after reset: slots above the fill counts are never looked at.
// Inserts into a full table are refused.
// ----------------------------------------------------------------------------
`default_nettype none

module user_id_registry_and_sessions_unit #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [uirs_pkg::REQ_W-1:0]         req_type_i,
  input  wire logic [uirs_pkg::USER_ID_W-1:0]     user_id_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    ok_o,
  output logic [uirs_pkg::COUNT_OUT_W-1:0]        registered_count_o,
  output logic [uirs_pkg::COUNT_OUT_W-1:0]        session_count_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                          state_q;
  logic [uirs_pkg::REQ_W-1:0]      op_q;
  logic [ID_BITS-1:0]              id_q;
  logic                            out_valid_q;
  logic                            ok_q;
  logic [uirs_pkg::COUNT_OUT_W-1:0] reg_cnt_q;
  logic [uirs_pkg::COUNT_OUT_W-1:0] ses_cnt_q;

  uirs_pkg::row_cmd_t  reg_cmd, ses_cmd;
  uirs_pkg::row_stat_t reg_stat, ses_stat;
  logic [CNT_W-1:0]    reg_count, ses_count;
  logic [CNT_W-1:0]    reg_count_d, ses_count_d;
  logic                ok_d;
  logic                commit;

  // Result register is free, or frees at this edge
  assign commit = (state_q == ST_EXEC) && !(out_valid_q && out_stall_i);

  // Registered-user table
  uirs_row #(
    .DEPTH (TABLE_DEPTH),
    .ID_W  (ID_BITS)
  ) u_reg_row (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (reg_cmd),
    .id_i         (id_q),
    .stat_o       (reg_stat),
    .count_o      (reg_count),
    .count_next_o (reg_count_d)
  );

  // Session table
  uirs_row #(
    .DEPTH (TABLE_DEPTH),
    .ID_W  (ID_BITS)
  ) u_ses_row (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ses_cmd),
    .id_i         (id_q),
    .stat_o       (ses_stat),
    .count_o      (ses_count),
    .count_next_o (ses_count_d)
  );

  // Request decode: success flag and table updates
  always_comb begin
    ok_d    = 1'b0;
    reg_cmd = '0;
    ses_cmd = '0;
    case (op_q)
      uirs_pkg::OP_REGISTER: begin
        ok_d           = !reg_stat.hit && !reg_stat.full;
        reg_cmd.append = commit && ok_d;
      end
      uirs_pkg::OP_REMOVE: begin
        ok_d         = reg_stat.hit;
        ses_cmd.drop = commit && ses_stat.hit;
        reg_cmd.drop = commit && reg_stat.hit;
      end
      uirs_pkg::OP_LOGIN: begin
        ok_d           = reg_stat.hit && !ses_stat.full;
        ses_cmd.append = commit && ok_d;
      end
      uirs_pkg::OP_LOGOUT: begin
        ok_d         = ses_stat.hit;
        ses_cmd.drop = commit && ses_stat.hit;
      end
      uirs_pkg::OP_QUERY_SES: begin
        ok_d = ses_stat.hit;
      end
      uirs_pkg::OP_QUERY_REG: begin
        ok_d = reg_stat.hit;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      id_q        <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      reg_cnt_q   <= '0;
      ses_cnt_q   <= '0;
    end else begin
      // Result beat leaves unless a new one takes its place
      if (out_valid_q && !out_stall_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= req_type_i;
            id_q    <= ID_BITS'(user_id_i);
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            out_valid_q <= 1'b1;
            ok_q        <= ok_d;
            reg_cnt_q   <= uirs_pkg::COUNT_OUT_W'(reg_count_d);
            ses_cnt_q   <= uirs_pkg::COUNT_OUT_W'(ses_count_d);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign ok_o               = ok_q;
  assign registered_count_o = reg_cnt_q;
  assign session_count_o    = ses_cnt_q;

  // Fill counts never pass capacity
  a_reg_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reg_count <= CNT_W'(TABLE_DEPTH))
    else $error("registry count above capacity");

  a_ses_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ses_count <= CNT_W'(TABLE_DEPTH))
    else $error("session count above capacity");

  // A new result beat only comes out of the execute step
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result beat without execute step");

  // Tables change only on a committed request
  a_tables_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(reg_count) && $stable(ses_count))
    else $error("table count changed outside commit");

endmodule

`default_nettype wire
